FILE: rtl/hjbp_pkg.sv
// ----------------------------------------------------------------------------
// hjbp_pkg
// Shared types and constants for the hash-join build/probe engine: field
// widths, hash multiplier, operation and status codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package hjbp_pkg;

   localparam int BUCKET_BITS_DEFAULT = 10;
   localparam int KEY_BITS_DEFAULT    = 32;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 10;
   localparam int TOTAL_W = 32;
   localparam int CSR_W   = 4;
   localparam int HASH_W  = 32;

   localparam logic [CSR_W-1:0]   CSR_RESET = 4'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // 64-bit golden-ratio multiplier, split into 32-bit halves
   localparam logic [HASH_W-1:0] HASH_MULT_LO = 32'h7F4A_7C15;
   localparam logic [HASH_W-1:0] HASH_MULT_HI = 32'h9E37_79B9;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_PROBE  = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef struct packed {
      logic clear;         // write one zero into the bucket-head store
      logic accept;        // capture a new transaction
      logic hash;          // finish the hash
      logic head_rd;       // read the bucket head
      logic link;          // insert, or start the chain walk
      logic rd_en;         // read key and link of one chain entry
      logic rd_from_link;  // address the read by the previous link
      logic walk;          // compare one chain entry
      logic load_out;      // load the result register
   } cmd_type;

   typedef struct packed {
      logic probe;
      logic head_empty;
      logic link_end;
      logic clr_last;
   } sts_type;

endpackage

FILE: rtl/hjbp_ctrl.sv
// ----------------------------------------------------------------------------
// hjbp_ctrl
// Controller: sequences the head-store clearing pass, the hash, the head
// read, the insert or chain walk, and the handoff to the result register.
// ----------------------------------------------------------------------------
module hjbp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  hjbp_pkg::sts_type sts,
   output hjbp_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_HASH  = 7'b0000100,
      ST_HEAD  = 7'b0001000,
      ST_LINK  = 7'b0010000,
      ST_WALK  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = ST_LINK;
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            if (sts.probe && !sts.head_empty) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (!sts.link_end) begin
               // follow the link read in the previous cycle
               cmd.rd_en        = 1'b1;
               cmd.rd_from_link = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/hjbp_dp.sv
// ----------------------------------------------------------------------------
// hjbp_dp
// Datapath: hash unit, bucket-head, link and key stores, entry allocator,
// match counter, saturating running total and the result register.
// ----------------------------------------------------------------------------
module hjbp_dp #(
   parameter int BUCKET_BITS = hjbp_pkg::BUCKET_BITS_DEFAULT,
   parameter int KEY_BITS    = hjbp_pkg::KEY_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hjbp_pkg::cmd_type            cmd,
   output hjbp_pkg::sts_type            sts,
   input  logic                         req_operation,
   input  logic [hjbp_pkg::KEY_W-1:0]   req_key,
   input  logic                         csr_wr,
   input  logic [hjbp_pkg::CSR_W-1:0]   csr_bucket_bits_in_use,
   output logic [hjbp_pkg::COUNT_W-1:0] rsp_match_count,
   output logic [hjbp_pkg::TOTAL_W-1:0] rsp_total_matches,
   output logic                         rsp_status
);

   localparam int ENTRIES = 1 << BUCKET_BITS;
   localparam int KW      = (KEY_BITS < hjbp_pkg::KEY_W) ? KEY_BITS : hjbp_pkg::KEY_W;
   localparam int BW      = $clog2(BUCKET_BITS + 1);
   localparam int CW      = (BW > hjbp_pkg::CSR_W) ? BW : hjbp_pkg::CSR_W;
   localparam logic [CW-1:0] BB_LIMIT = CW'(BUCKET_BITS);

   // storage
   logic [BUCKET_BITS-1:0] heads_mem [ENTRIES];
   logic [BUCKET_BITS-1:0] link_mem  [ENTRIES];
   logic [KW-1:0]          key_mem   [ENTRIES];

   // control-side registers
   logic [hjbp_pkg::CSR_W-1:0]   csr_ff;
   logic [BUCKET_BITS:0]         next_free_ff;
   logic [hjbp_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [BUCKET_BITS-1:0]       clr_ff;

   // item registers
   logic                         op_ff;
   logic [KW-1:0]                key_ff;
   logic [hjbp_pkg::HASH_W-1:0]  hlo_ff;
   logic [hjbp_pkg::HASH_W-1:0]  hash_ff;
   logic [BUCKET_BITS-1:0]       bucket_ff;
   logic [BUCKET_BITS-1:0]       head_rd_ff;
   logic [BUCKET_BITS-1:0]       link_rd_ff;
   logic [KW-1:0]                key_rd_ff;
   logic [hjbp_pkg::COUNT_W-1:0] count_ff;
   logic                         drop_ff;

   // result register
   logic [hjbp_pkg::COUNT_W-1:0] out_count_ff;
   logic [hjbp_pkg::TOTAL_W-1:0] out_total_ff;
   logic                         out_status_ff;

   logic [63:0]                  prod_lo_c;
   logic [hjbp_pkg::HASH_W-1:0]  prod_hi_c;
   logic [CW-1:0]                csr_x;
   logic [CW-1:0]                bits_c;
   logic [CW-1:0]                shamt_c;
   logic [BUCKET_BITS-1:0]       top_bits_c;
   logic [BUCKET_BITS-1:0]       bucket_c;
   logic                         full_c;
   logic                         ins_we;
   logic [BUCKET_BITS-1:0]       pos_c;
   logic [BUCKET_BITS-1:0]       rd_addr_c;
   logic                         hit_c;
   logic [hjbp_pkg::TOTAL_W:0]   sum_c;
   logic                         head_we;
   logic [BUCKET_BITS-1:0]       head_wa;
   logic [BUCKET_BITS-1:0]       head_wd;

   // hash: bits 63..32 of key * 64-bit multiplier (mod 2**64), low half first
   assign prod_lo_c = 64'(req_key[KW-1:0]) * 64'(hjbp_pkg::HASH_MULT_LO);
   assign prod_hi_c = hjbp_pkg::HASH_W'(key_ff) * hjbp_pkg::HASH_MULT_HI;

   // clamp the bucket-bit setting to 1..BUCKET_BITS
   assign csr_x   = CW'(csr_ff);
   assign bits_c  = (csr_x == '0) ? CW'(1) : ((csr_x > BB_LIMIT) ? BB_LIMIT : csr_x);
   assign shamt_c = BB_LIMIT - bits_c;

   assign top_bits_c = hash_ff[hjbp_pkg::HASH_W-1 -: BUCKET_BITS];
   assign bucket_c   = top_bits_c >> shamt_c;

   assign full_c    = next_free_ff[BUCKET_BITS];
   assign pos_c     = next_free_ff[BUCKET_BITS-1:0];
   assign ins_we    = cmd.link && (op_ff == hjbp_pkg::OP_INSERT) && !full_c;
   assign rd_addr_c = cmd.rd_from_link ? link_rd_ff : head_rd_ff;
   assign hit_c     = (key_rd_ff == key_ff);
   assign sum_c     = {1'b0, total_ff} + (hjbp_pkg::TOTAL_W + 1)'(count_ff);
   assign total_in  = sum_c[hjbp_pkg::TOTAL_W] ? hjbp_pkg::TOTAL_MAX
                                               : sum_c[hjbp_pkg::TOTAL_W-1:0];

   // one write port on the head store: clearing pass or chain push
   assign head_we = cmd.clear || ins_we;
   assign head_wa = cmd.clear ? clr_ff : bucket_ff;
   assign head_wd = cmd.clear ? '0 : pos_c;

   always_ff @(posedge clock) begin
      if (head_we) begin
         heads_mem[head_wa] <= head_wd;
      end
      if (cmd.head_rd) begin
         head_rd_ff <= heads_mem[bucket_c];
      end
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         link_mem[pos_c] <= head_rd_ff;
         key_mem[pos_c]  <= key_ff;
      end
      if (cmd.rd_en) begin
         link_rd_ff <= link_mem[rd_addr_c];
         key_rd_ff  <= key_mem[rd_addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= hjbp_pkg::CSR_RESET;
         next_free_ff <= (BUCKET_BITS + 1)'(1);
         total_ff     <= '0;
         clr_ff       <= '0;
      end else begin
         if (csr_wr) begin
            csr_ff <= csr_bucket_bits_in_use;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (ins_we) begin
            next_free_ff <= next_free_ff + 1'b1;
         end
         if (cmd.load_out) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_operation;
         key_ff <= req_key[KW-1:0];
         hlo_ff <= prod_lo_c[63:32];
      end
      if (cmd.hash) begin
         hash_ff <= hlo_ff + prod_hi_c;
      end
      if (cmd.head_rd) begin
         bucket_ff <= bucket_c;
         count_ff  <= '0;
      end
      if (cmd.link) begin
         drop_ff <= (op_ff == hjbp_pkg::OP_INSERT) && full_c;
      end
      if (cmd.walk && hit_c && (count_ff != hjbp_pkg::COUNT_MAX)) begin
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.load_out) begin
         out_count_ff  <= count_ff;
         out_total_ff  <= total_in;
         out_status_ff <= drop_ff ? hjbp_pkg::STATUS_DROPPED : hjbp_pkg::STATUS_DONE;
      end
   end

   assign sts.probe      = (op_ff == hjbp_pkg::OP_PROBE);
   assign sts.head_empty = (head_rd_ff == '0);
   assign sts.link_end   = (link_rd_ff == '0);
   assign sts.clr_last   = (clr_ff == '1);

   assign rsp_match_count   = out_count_ff;
   assign rsp_total_matches = out_total_ff;
   assign rsp_status        = out_status_ff;

endmodule

FILE: rtl/hash_join_build_probe.sv
// ----------------------------------------------------------------------------
// hash_join_build_probe
// Sequence: an accepted item is hashed, its bucket head is read, then an
// insert links it in or a probe walks the chain of its bucket, and the
// result register is loaded once it is free. One item is taken at a time;
// the chain walk reads one entry per cycle from the link and key stores.
// Reset: synchronous; a clearing pass then writes zero to all 2**BUCKET_BITS
// entries of the bucket-head store, during which no item is taken.
// Chained-bucket hash join engine: inserts build keys, probes count matches.
// ----------------------------------------------------------------------------
module hash_join_build_probe #(
   parameter int BUCKET_BITS = hjbp_pkg::BUCKET_BITS_DEFAULT,
   parameter int KEY_BITS    = hjbp_pkg::KEY_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [hjbp_pkg::KEY_W-1:0]   req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hjbp_pkg::COUNT_W-1:0] rsp_match_count,
   output logic [hjbp_pkg::TOTAL_W-1:0] rsp_total_matches,
   output logic                         rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hjbp_pkg::CSR_W-1:0]   csr_bucket_bits_in_use
);

   hjbp_pkg::cmd_type cmd;
   hjbp_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   hjbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hjbp_dp #(
      .BUCKET_BITS (BUCKET_BITS),
      .KEY_BITS    (KEY_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_operation          (req_operation),
      .req_key                (req_key),
      .csr_wr                 (csr_valid && csr_ready),
      .csr_bucket_bits_in_use (csr_bucket_bits_in_use),
      .rsp_match_count        (rsp_match_count),
      .rsp_total_matches      (rsp_total_matches),
      .rsp_status             (rsp_status)
   );

   // the head store has one write port
   a_one_head_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear && cmd.link && !sts.probe))
      else $error("clearing pass and insert collide on the head store");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("result shown without a load");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new transaction taken while one is in work");

endmodule
